// ----- rtl/cdll_pkg.sv -----
// Package for the cursor doubly linked list: sizes, opcode and status codes,
// and the request and result records passed between the list modules.
// No dependencies.
package cdll_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;

  // Fixed widths of the item fields
  localparam int OPCODE_W = 3;
  localparam int DATA_W   = 32;
  localparam int COUNT_FW = 5;

  // A slot number also encodes the null marker, which is CAPACITY
  localparam int SLOT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int COUNT_W = $clog2(CAPACITY + 1);
  // Only the low 32 bits of an appended value ever reach the store
  localparam int STORE_W = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;

  localparam logic [SLOT_W-1:0] NULL_SLOT = SLOT_W'(CAPACITY);

  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND = 3'd0,
    OP_FIRST  = 3'd1,
    OP_NEXT   = 3'd2,
    OP_PREV   = 3'd3,
    OP_REMOVE = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_END       = 2'd1,
    ST_FULL      = 2'd2,
    ST_NO_CURSOR = 2'd3
  } status_e;

  typedef struct packed {
    op_e                op;
    logic [STORE_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_e                   status;
    logic signed [DATA_W-1:0]  read_value;
    logic [COUNT_W-1:0]        count;
  } res_t;

endpackage

// ----- rtl/cdll_free_find.sv -----
// Lowest free slot search over the free map.
// Depends on cdll_pkg for the capacity and slot index width.
module cdll_free_find (
  input  logic [cdll_pkg::CAPACITY-1:0] free_i,
  output logic                          found_o,
  output logic [cdll_pkg::IDX_W-1:0]    idx_o
);

  always_comb begin
    idx_o = '0;
    // scan downward so the lowest free slot wins
    for (int i = cdll_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (free_i[i]) begin
        idx_o = cdll_pkg::IDX_W'(i);
      end
    end
  end

  assign found_o = |free_i;

endmodule

// ----- rtl/cdll_core.sv -----
// List state (values, forward and backward links, free map, head, tail,
// cursor, count) and the combinational operation logic.
// Depends on cdll_pkg and cdll_free_find.
module cdll_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  cdll_pkg::req_t    req_i,
  output cdll_pkg::res_t    res_o
);

  localparam int CAP = cdll_pkg::CAPACITY;

  logic [cdll_pkg::STORE_W-1:0] val_q [CAP];
  logic [cdll_pkg::STORE_W-1:0] val_d [CAP];
  logic [cdll_pkg::SLOT_W-1:0]  fwd_q [CAP];
  logic [cdll_pkg::SLOT_W-1:0]  fwd_d [CAP];
  logic [cdll_pkg::SLOT_W-1:0]  bwd_q [CAP];
  logic [cdll_pkg::SLOT_W-1:0]  bwd_d [CAP];

  logic [CAP-1:0]               free_q, free_d;
  logic [cdll_pkg::SLOT_W-1:0]  first_q, first_d;
  logic [cdll_pkg::SLOT_W-1:0]  last_q, last_d;
  logic [cdll_pkg::SLOT_W-1:0]  cursor_q, cursor_d;
  logic [cdll_pkg::COUNT_W-1:0] count_q, count_d;

  logic                         free_found;
  logic [cdll_pkg::IDX_W-1:0]   free_idx;
  logic [cdll_pkg::SLOT_W-1:0]  free_slot;

  logic                         cur_ok, first_ok, last_ok, prev_ok, next_ok, step_ok;
  logic [cdll_pkg::IDX_W-1:0]   cur_idx;
  logic [cdll_pkg::SLOT_W-1:0]  cur_fwd, cur_bwd, step_slot, rd_slot;
  logic [cdll_pkg::STORE_W-1:0] rd_val;
  logic signed [cdll_pkg::DATA_W-1:0] rd_ext;

  cdll_free_find u_free_find (
    .free_i  (free_q),
    .found_o (free_found),
    .idx_o   (free_idx)
  );

  assign free_slot = cdll_pkg::SLOT_W'(free_idx);

  assign cur_ok   = cursor_q < cdll_pkg::NULL_SLOT;
  assign first_ok = first_q < cdll_pkg::NULL_SLOT;
  assign last_ok  = last_q < cdll_pkg::NULL_SLOT;
  assign cur_idx  = cursor_q[cdll_pkg::IDX_W-1:0];
  assign cur_fwd  = fwd_q[cur_idx];
  assign cur_bwd  = bwd_q[cur_idx];
  assign prev_ok  = cur_bwd < cdll_pkg::NULL_SLOT;
  assign next_ok  = cur_fwd < cdll_pkg::NULL_SLOT;

  // next from before the first entry goes to the head
  assign step_slot = cur_ok ? cur_fwd : first_q;
  assign step_ok   = step_slot < cdll_pkg::NULL_SLOT;

  // one value read port, address chosen by the operation
  always_comb begin
    case (req_i.op)
      cdll_pkg::OP_FIRST: rd_slot = first_q;
      cdll_pkg::OP_NEXT:  rd_slot = step_slot;
      cdll_pkg::OP_PREV:  rd_slot = cur_bwd;
      default:            rd_slot = cursor_q;
    endcase
  end

  assign rd_val = val_q[rd_slot[cdll_pkg::IDX_W-1:0]];
  assign rd_ext = cdll_pkg::DATA_W'(signed'(rd_val));

  always_comb begin
    val_d    = val_q;
    fwd_d    = fwd_q;
    bwd_d    = bwd_q;
    free_d   = free_q;
    first_d  = first_q;
    last_d   = last_q;
    cursor_d = cursor_q;
    count_d  = count_q;
    res_o.status     = cdll_pkg::ST_OK;
    res_o.read_value = '0;

    case (req_i.op)
      cdll_pkg::OP_APPEND: begin
        if (count_q >= cdll_pkg::COUNT_W'(CAP) || !free_found) begin
          res_o.status = cdll_pkg::ST_FULL;
        end else begin
          free_d[free_idx] = 1'b0;
          val_d[free_idx]  = req_i.value;
          fwd_d[free_idx]  = cdll_pkg::NULL_SLOT;
          bwd_d[free_idx]  = last_q;
          if (last_ok) begin
            fwd_d[last_q[cdll_pkg::IDX_W-1:0]] = free_slot;
          end else begin
            first_d = free_slot;
          end
          last_d  = free_slot;
          count_d = count_q + cdll_pkg::COUNT_W'(1);
        end
      end
      cdll_pkg::OP_FIRST: begin
        if (!first_ok) begin
          res_o.status = cdll_pkg::ST_END;
        end else begin
          cursor_d         = first_q;
          res_o.read_value = rd_ext;
        end
      end
      cdll_pkg::OP_NEXT: begin
        if (!step_ok) begin
          res_o.status = cdll_pkg::ST_END;
        end else begin
          cursor_d         = step_slot;
          res_o.read_value = rd_ext;
        end
      end
      cdll_pkg::OP_PREV: begin
        if (!cur_ok || !prev_ok) begin
          res_o.status = cdll_pkg::ST_END;
        end else begin
          cursor_d         = cur_bwd;
          res_o.read_value = rd_ext;
        end
      end
      cdll_pkg::OP_REMOVE: begin
        if (!cur_ok || free_q[cur_idx]) begin
          res_o.status = cdll_pkg::ST_NO_CURSOR;
        end else begin
          res_o.read_value = rd_ext;
          // unlink: neighbors point past the cursor entry
          if (prev_ok) begin
            fwd_d[cur_bwd[cdll_pkg::IDX_W-1:0]] = cur_fwd;
          end else begin
            first_d = cur_fwd;
          end
          if (next_ok) begin
            bwd_d[cur_fwd[cdll_pkg::IDX_W-1:0]] = cur_bwd;
          end else begin
            last_d = cur_bwd;
          end
          free_d[cur_idx] = 1'b1;
          cursor_d        = prev_ok ? cur_bwd : cdll_pkg::NULL_SLOT;
          if (count_q != '0) begin
            count_d = count_q - cdll_pkg::COUNT_W'(1);
          end
        end
      end
      default: begin
        // unused codes leave everything alone
      end
    endcase

    res_o.count = count_d;
  end

  // entry stores carry no reset: a slot is read only after it was linked
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_d;
      fwd_q <= fwd_d;
      bwd_q <= bwd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q   <= '1;
      first_q  <= cdll_pkg::NULL_SLOT;
      last_q   <= cdll_pkg::NULL_SLOT;
      cursor_q <= cdll_pkg::NULL_SLOT;
      count_q  <= '0;
    end else if (en_i) begin
      free_q   <= free_d;
      first_q  <= first_d;
      last_q   <= last_d;
      cursor_q <= cursor_d;
      count_q  <= count_d;
    end
  end

  a_count_matches_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(~free_q) == int'(count_q))
    else $error("entry count disagrees with free map");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cdll_pkg::COUNT_W'(CAP))
    else $error("entry count above capacity");

  a_head_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((count_q == '0) == !first_ok) && ((count_q == '0) == !last_ok))
    else $error("head or tail marker disagrees with entry count");

  a_cursor_linked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_ok |-> !free_q[cur_idx])
    else $error("cursor points at a free slot");

endmodule

// ----- rtl/cursor_doubly_linked_list.sv -----
// Top level of the cursor doubly linked list: input register, result
// register and valid/ready handshake around the list core.
// Depends on cdll_pkg and cdll_core.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i / in_ready_o  opcode_i, item_value_i
//   out      source     out_valid_o / out_ready_i status_o, read_value_o, entry_count_o
//
// One item per cycle sustained while out_ready_i is high; a result is offered
// once its item has passed both registers (the input register takes the item,
// then the core updates state and loads the result register).
// Reset empties the list and parks the cursor before the first entry.
// A held result stalls the core; the input register still takes one item.
module cursor_doubly_linked_list (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [cdll_pkg::OPCODE_W-1:0]       opcode_i,
  input  logic signed [cdll_pkg::DATA_W-1:0]  item_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          status_o,
  output logic signed [cdll_pkg::DATA_W-1:0]  read_value_o,
  output logic [cdll_pkg::COUNT_FW-1:0]       entry_count_o
);

  logic           in_valid_q;
  cdll_pkg::req_t req_q;
  logic           out_valid_q;
  cdll_pkg::res_t res_q;
  cdll_pkg::res_t core_res;
  logic           advance, fire;

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q.op    <= cdll_pkg::op_e'(opcode_i);
      req_q.value <= item_value_i[cdll_pkg::STORE_W-1:0];
    end
    if (fire) begin
      res_q <= core_res;
    end
  end

  cdll_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (fire),
    .req_i  (req_q),
    .res_o  (core_res)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = res_q.status;
  assign read_value_o  = res_q.read_value;
  assign entry_count_o = cdll_pkg::COUNT_FW'(res_q.count);

endmodule
